// ----- rtl/core/tsba_pkg.sv -----
// Package: widths, limits, codes and helpers shared by the slot allocator files.
package tsba_pkg;

  // Address and geometry
  localparam int ADDR_W         = 48;
  localparam int MAX_PAGES      = 64;
  localparam int PAGE_BYTES     = 4096;
  localparam int SLOT_BYTES     = 512;
  localparam int SLOTS_PER_PAGE = 8;

  localparam int PAGE_W     = $clog2(MAX_PAGES);
  localparam int COUNT_W    = $clog2(MAX_PAGES + 1);
  localparam int SLOT_W     = $clog2(SLOTS_PER_PAGE);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int SLOT_SHIFT = $clog2(SLOT_BYTES);
  localparam int OFF_PAGE_W = ADDR_W - PAGE_SHIFT;
  localparam int OFF_SLOT_W = PAGE_SHIFT - SLOT_SHIFT;

  typedef logic [SLOTS_PER_PAGE-1:0] bitmap_t;

  // Request codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Full-flag update from the sequencer to the page finder
  typedef struct packed {
    logic              en;
    logic [PAGE_W-1:0] page;
    logic              full;
  } full_upd_t;

  // Lowest clear bit of a page map (map is known not to be all ones)
  function automatic logic [SLOT_W-1:0] first_zero(input bitmap_t map);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS_PER_PAGE - 1; i >= 0; i--) begin
      if (!map[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

endpackage

// ----- rtl/core/tsba_if.sv -----
// Interfaces: request, result and configuration channels of the slot allocator.
interface tsba_req_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [tsba_pkg::ADDR_W-1:0] free_address;

  modport source (output valid, output action, output free_address, input ready);
  modport sink   (input valid, input action, input free_address, output ready);
endinterface

interface tsba_res_if;
  logic                        valid;
  logic                        ready;
  logic [tsba_pkg::ADDR_W-1:0] slot_address;
  logic                        opened_page;
  logic [1:0]                  status;

  modport source (output valid, output slot_address, output opened_page, output status,
                  input ready);
  modport sink   (input valid, input slot_address, input opened_page, input status,
                  output ready);
endinterface

interface tsba_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tsba_pkg::ADDR_W-1:0] region_base;

  modport source (output valid, output region_base, input ready);
  modport sink   (input valid, input region_base, output ready);
endinterface

// ----- rtl/core/tsba_ram.sv -----
// Generic single-port-write, registered-read RAM for the page bitmaps.
module tsba_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/tsba_page_finder.sv -----
// Page finder: per-page full flags and priority encoder over the open pages.
module tsba_page_finder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tsba_pkg::full_upd_t                upd_i,
  input  logic [tsba_pkg::COUNT_W-1:0]       pages_i,
  output logic                               found_o,
  output logic [tsba_pkg::PAGE_W-1:0]        page_o
);

  logic [tsba_pkg::MAX_PAGES-1:0] full_q;
  logic [tsba_pkg::MAX_PAGES-1:0] cand;

  // full flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= '0;
    end else if (upd_i.en) begin
      full_q[upd_i.page] <= upd_i.full;
    end
  end

  // open and not full
  always_comb begin
    for (int p = 0; p < tsba_pkg::MAX_PAGES; p++) begin
      cand[p] = !full_q[p] && (tsba_pkg::COUNT_W'(p) < pages_i);
    end
  end

  // lowest candidate wins
  always_comb begin
    page_o = '0;
    for (int p = tsba_pkg::MAX_PAGES - 1; p >= 0; p--) begin
      if (cand[p]) page_o = tsba_pkg::PAGE_W'(p);
    end
  end

  assign found_o = |cand;

endmodule

// ----- rtl/core/tls_slot_bitmap_allocator.sv -----
// Top level: first-fit thread-local slot allocator over per-page slot bitmaps.
//
// Channels: req_i takes a request word (action, free_address); res_o gives one
// result word (slot_address, opened_page, status) per request; cfg_i writes the
// region base and is always ready. Write the base only while the block is idle.
// An allocate takes the lowest free slot of the lowest open page that is not
// full, opens the next page when all are full, or reports full at the limit.
// A free clears the bit of its address's page and slot, or reports out of range.
// The request is held in registers while its page map is read; the result is
// then registered in the output register. A new request is taken only when idle,
// as the single bitmap memory reads the map, then modifies and writes it back.
// The page to touch is picked at accept time by a priority encoder over
// per-page full flags, so no search through the memory is needed.
// Reset clears the full flags, the open-page count and the base; the bitmap
// memory needs no clearing, as a page's map is written whole when it is opened.
// When the receiver stalls, the result holds in the output register; one more
// request may be taken and waits after its read until the result leaves.
module tls_slot_bitmap_allocator (
  input logic        clk_i,
  input logic        rst_ni,
  tsba_req_if.sink   req_i,
  tsba_res_if.source res_o,
  tsba_cfg_if.sink   cfg_i
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic                              state_q, state_d;
  logic [tsba_pkg::ADDR_W-1:0]       base_q;
  logic [tsba_pkg::COUNT_W-1:0]      pages_q, pages_d;
  logic                              act_q;
  logic [tsba_pkg::PAGE_W-1:0]       page_q;
  logic [tsba_pkg::SLOT_W-1:0]       slot_q;
  logic                              opened_q;
  logic [1:0]                        status_q;

  logic                              out_valid_q;
  logic [tsba_pkg::ADDR_W-1:0]       out_addr_q;
  logic                              out_opened_q;
  logic [1:0]                        out_status_q;

  logic                              accept;
  logic                              finish;
  logic                              found;
  logic [tsba_pkg::PAGE_W-1:0]       found_page;
  logic [tsba_pkg::ADDR_W-1:0]       offset;
  logic [tsba_pkg::OFF_PAGE_W-1:0]   off_page;
  logic [tsba_pkg::OFF_SLOT_W-1:0]   off_slot;

  logic [tsba_pkg::PAGE_W-1:0]       page_d;
  logic [tsba_pkg::SLOT_W-1:0]       slot_d;
  logic                              opened_d;
  logic [1:0]                        status_d;

  tsba_pkg::bitmap_t                 rdata;
  tsba_pkg::bitmap_t                 cur_map;
  tsba_pkg::bitmap_t                 new_map;
  logic [tsba_pkg::SLOT_W-1:0]       use_slot;
  logic                              wr_en;
  logic [tsba_pkg::ADDR_W-1:0]       res_addr;
  tsba_pkg::full_upd_t               upd;

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign finish      = (state_q == S_EXEC) && (!out_valid_q || res_o.ready);
  assign cfg_i.ready = 1'b1;

  // base register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      base_q <= cfg_i.region_base;
    end
  end

  tsba_page_finder u_finder (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (upd),
    .pages_i (pages_q),
    .found_o (found),
    .page_o  (found_page)
  );

  // free address decode
  assign offset   = req_i.free_address - base_q;
  assign off_page = offset[tsba_pkg::ADDR_W-1:tsba_pkg::PAGE_SHIFT];
  assign off_slot = offset[tsba_pkg::PAGE_SHIFT-1:tsba_pkg::SLOT_SHIFT];

  // request decision at accept time
  always_comb begin
    page_d   = found_page;
    slot_d   = '0;
    opened_d = 1'b0;
    status_d = tsba_pkg::ST_OK;
    if (req_i.action == tsba_pkg::ACT_ALLOC) begin
      if (!found) begin
        if (pages_q >= tsba_pkg::COUNT_W'(tsba_pkg::MAX_PAGES)) begin
          status_d = tsba_pkg::ST_FULL;
        end else begin
          page_d   = pages_q[tsba_pkg::PAGE_W-1:0];
          opened_d = 1'b1;
        end
      end
    end else begin
      page_d = off_page[tsba_pkg::PAGE_W-1:0];
      slot_d = off_slot[tsba_pkg::SLOT_W-1:0];
      if (off_page >= tsba_pkg::OFF_PAGE_W'(pages_q) ||
          32'(off_slot) >= tsba_pkg::SLOTS_PER_PAGE) begin
        status_d = tsba_pkg::ST_RANGE;
      end
    end
  end

  tsba_ram #(
    .DEPTH (tsba_pkg::MAX_PAGES),
    .WIDTH (tsba_pkg::SLOTS_PER_PAGE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (page_q),
    .wdata_i (new_map),
    .re_i    (accept),
    .raddr_i (page_d),
    .rdata_o (rdata)
  );

  // read-modify-write of the page map
  always_comb begin
    cur_map  = opened_q ? '0 : rdata;
    use_slot = (act_q == tsba_pkg::ACT_ALLOC) ? tsba_pkg::first_zero(cur_map) : slot_q;
    new_map  = cur_map;
    if (act_q == tsba_pkg::ACT_ALLOC) new_map[use_slot] = 1'b1;
    else                              new_map[use_slot] = 1'b0;
  end

  assign wr_en     = finish && (status_q == tsba_pkg::ST_OK);
  assign upd.en    = wr_en;
  assign upd.page  = page_q;
  assign upd.full  = &new_map;
  assign res_addr  = base_q
                   + (tsba_pkg::ADDR_W'(page_q) << tsba_pkg::PAGE_SHIFT)
                   + (tsba_pkg::ADDR_W'(use_slot) << tsba_pkg::SLOT_SHIFT);

  // open-page count
  always_comb begin
    pages_d = pages_q;
    if (wr_en && opened_q) pages_d = pages_q + 1'b1;
  end

  // sequencer and open-page count
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_EXEC;
      S_EXEC:  if (finish) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pages_q <= '0;
    end else begin
      state_q <= state_d;
      pages_q <= pages_d;
    end
  end

  // request held through the read cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q    <= req_i.action;
      page_q   <= page_d;
      slot_q   <= slot_d;
      opened_q <= opened_d;
      status_q <= status_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_opened_q <= opened_q;
      out_status_q <= status_q;
      out_addr_q   <= (act_q == tsba_pkg::ACT_ALLOC && status_q == tsba_pkg::ST_OK)
                      ? res_addr : '0;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.slot_address = out_addr_q;
  assign res_o.opened_page  = out_opened_q;
  assign res_o.status       = out_status_q;

  // checks
  a_pages_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pages_q <= tsba_pkg::COUNT_W'(tsba_pkg::MAX_PAGES))
    else $error("open page count beyond limit");

  a_pages_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pages_q != $past(pages_q)) |-> (pages_q == $past(pages_q) + 1'b1))
    else $error("open page count moved by more than one");

  a_open_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.opened_page) |-> (res_o.status == tsba_pkg::ST_OK))
    else $error("page opened on a failed request");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |=> !$past(finish))
    else $error("result overwritten while stalled");

endmodule
